FILE: src/csvrs_pkg.sv
`timescale 1ns / 1ps

package csvrs_pkg;

	// Characters with a meaning to the parser.
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// Input operation codes.
	localparam logic OP_DATA = 1'b0;
	localparam logic OP_END  = 1'b1;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_BYTE   = 2'd0,
		KIND_FIELD  = 2'd1,
		KIND_RECORD = 2'd2,
		KIND_ERROR  = 2'd3
	} kind_t;

	// One input transaction held in the input register.
	typedef struct packed {
		logic       valid;
		logic       op;
		logic [7:0] data_byte;
	} item_t;

	// Result of one parsing step; emit is low when the byte gives no result.
	typedef struct packed {
		logic       emit;
		kind_t      kind;
		logic [7:0] field_byte;
	} result_t;

endpackage

FILE: src/csvrs_in_stage.sv
`timescale 1ns / 1ps

module csvrs_in_stage
	import csvrs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       op,
	input  logic [7:0] data_byte,
	input  logic       fire,
	output item_t      item
);

	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;
	logic       take;

	// The register may be refilled in the same cycle that its item moves on.
	assign in_stall = valid_s1 && !fire;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1   <= op;
			byte_s1 <= data_byte;
		end
	end

	assign item = '{valid: valid_s1, op: op_s1, data_byte: byte_s1};

endmodule

FILE: src/csvrs_step.sv
`timescale 1ns / 1ps

module csvrs_step
	import csvrs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	output result_t res
);

	logic in_quotes_q;
	logic quote_pending_q;
	logic skip_linefeed_q;
	logic record_open_q;

	logic in_quotes_d;
	logic quote_pending_d;
	logic skip_linefeed_d;
	logic record_open_d;
	logic quoted_eff;
	logic [7:0] c;

	assign c = item.data_byte;

	always_comb begin
		in_quotes_d     = in_quotes_q;
		quote_pending_d = quote_pending_q;
		skip_linefeed_d = skip_linefeed_q;
		record_open_d   = record_open_q;
		quoted_eff      = in_quotes_q;
		res             = '{emit: 1'b0, kind: KIND_BYTE, field_byte: 8'h00};

		if (item.op == OP_END) begin
			// A pending quote closes quoting before the final check.
			quoted_eff      = in_quotes_q ^ quote_pending_q;
			in_quotes_d     = 1'b0;
			quote_pending_d = 1'b0;
			skip_linefeed_d = 1'b0;
			record_open_d   = 1'b0;
			if (quoted_eff) begin
				res.emit = 1'b1;
				res.kind = KIND_ERROR;
			end else if (record_open_q) begin
				res.emit = 1'b1;
				res.kind = KIND_RECORD;
			end
		end else if (skip_linefeed_q && c == CH_LF) begin
			// Linefeed of a CR LF pair is dropped.
			skip_linefeed_d = 1'b0;
		end else begin
			skip_linefeed_d = 1'b0;
			quote_pending_d = 1'b0;
			if (quote_pending_q && c == CH_QUOTE) begin
				// Doubled quote inside quotes is one literal quote.
				record_open_d  = 1'b1;
				res.emit       = 1'b1;
				res.field_byte = c;
			end else begin
				if (quote_pending_q) begin
					quoted_eff = 1'b0;
				end
				in_quotes_d = quoted_eff;
				if (quoted_eff) begin
					if (c == CH_QUOTE) begin
						quote_pending_d = 1'b1;
					end else begin
						record_open_d  = 1'b1;
						res.emit       = 1'b1;
						res.field_byte = c;
					end
				end else if (c == CH_QUOTE) begin
					in_quotes_d = 1'b1;
				end else if (c == CH_COMMA) begin
					record_open_d = 1'b1;
					res.emit      = 1'b1;
					res.kind      = KIND_FIELD;
				end else if (c == CH_CR || c == CH_LF) begin
					record_open_d   = 1'b0;
					skip_linefeed_d = (c == CH_CR);
					res.emit        = 1'b1;
					res.kind        = KIND_RECORD;
				end else begin
					record_open_d  = 1'b1;
					res.emit       = 1'b1;
					res.field_byte = c;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_quotes_q     <= 1'b0;
			quote_pending_q <= 1'b0;
			skip_linefeed_q <= 1'b0;
			record_open_q   <= 1'b0;
		end else if (fire) begin
			in_quotes_q     <= in_quotes_d;
			quote_pending_q <= quote_pending_d;
			skip_linefeed_q <= skip_linefeed_d;
			record_open_q   <= record_open_d;
		end
	end

`ifndef SYNTH
	// A quote can only be held for lookahead while quoting is open.
	a_pending_in_quotes: assert property (@(posedge clk) disable iff (!arst_n)
		quote_pending_q |-> in_quotes_q)
		else $error("quote pending outside quotes");

	// A CR that ended a record leaves the parser unquoted with no open record.
	a_skip_clean: assert property (@(posedge clk) disable iff (!arst_n)
		skip_linefeed_q |-> (!in_quotes_q && !record_open_q))
		else $error("linefeed skip with quoted or open record");

	// End of input always leaves every state bit cleared.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.op == OP_END) |=>
		(!in_quotes_q && !quote_pending_q && !skip_linefeed_q && !record_open_q))
		else $error("state not cleared at end of input");
`endif

endmodule

FILE: src/csvrs_out_stage.sv
`timescale 1ns / 1ps

module csvrs_out_stage
	import csvrs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  result_t    res,
	output logic       can_take,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] field_byte
);

	logic       out_valid_q;
	kind_t      kind_q;
	logic [7:0] field_byte_q;

	// A new result may replace one that is being taken in this cycle.
	assign can_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.emit) begin
			kind_q       <= res.kind;
			field_byte_q <= res.field_byte;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign field_byte = field_byte_q;

`ifndef SYNTH
	// Only content bytes carry a nonzero byte value.
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q != KIND_BYTE) |-> (field_byte_q == 8'h00))
		else $error("nonzero byte on a non-content result");
`endif

endmodule

FILE: src/csv_record_splitter.sv
`timescale 1ns / 1ps

// CSV record splitter: turns a byte stream into CSV field bytes, field ends
// and record ends.
// Input channel: in_valid / in_stall with op and data_byte. op selects a data
// byte or the end of input; the byte is ignored at end of input.
// Output channel: out_valid / out_stall with kind and field_byte. Each input
// transaction gives zero or one output transaction: a content byte, an end
// of field, an end of field and record, or an unterminated quote error.
// Throughput is one input transaction per clock cycle while the receiver
// does not stall. The parser state is four flag bits updated by one short
// step of logic between the input register and the result register, which
// is what allows that rate. An accepted item waits in the input register, is
// parsed as it moves on, and its result is offered from the result register.
// When the receiver stalls, the held result stays on the output; one more
// item waits in the input register and in_stall then rises.
// Reset clears the parser flags and both valid bits; nothing is pending.

module csv_record_splitter
	import csvrs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       op,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] field_byte
);

	item_t   item;
	result_t res;
	logic    can_take;
	logic    fire;

	// The held item is parsed whenever the result register has room for it.
	assign fire = item.valid && can_take;

	csvrs_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.data_byte (data_byte),
		.fire      (fire),
		.item      (item)
	);

	csvrs_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item),
		.res    (res)
	);

	csvrs_out_stage u_out_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.res        (res),
		.can_take   (can_take),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.field_byte (field_byte)
	);

`ifndef SYNTH
	// The input side stalls only while a parsed item is blocked downstream.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (item.valid && out_valid && out_stall))
		else $error("input stalled without a blocked result");

	// A blocked result keeps its kind while the next item waits.
	a_hold_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(kind)))
		else $error("held result changed under stall");
`endif

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the CSV record splitter.
// A queue of pending byte transactions is filled up front: a short directed
// list, then random records (mostly well-formed CSV with random content, some
// noise and some broken quoting). A clocked driver sends them with random
// gaps. At every accepted input transaction it steps a local parser model
// and queues the result token that the block should give. A clocked monitor
// applies random stalls on the output and compares every accepted result,
// field by field, with the oldest queued token.

module tb_top
	import csvrs_pkg::*;
();

	localparam int RANDOM_ITEMS = 1450;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int PRINT_LIMIT  = 50;

	// One input transaction waiting to be sent.
	typedef struct {
		logic       op;
		logic [7:0] data;
	} csv_input_t;

	// One result token as the block should deliver it.
	typedef struct {
		kind_t      kind;
		logic [7:0] fbyte;
	} csv_token_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       op = OP_DATA;
	logic [7:0] data_byte = 8'h00;
	logic       out_stall = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic [1:0] kind;
	logic [7:0] field_byte;

	csv_input_t pending_inputs[$];
	csv_token_t expected_tokens[$];
	int         mismatches = 0;
	int         generated = 0;
	int         cycle_count = 0;

	// Local copy of the parser flags, stepped once per accepted transaction.
	bit quoting;
	bit quote_held;
	bit after_cr;
	bit record_started;

	csv_record_splitter i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.field_byte (field_byte)
	);

	always #2 clk = ~clk;

	// Prints one line per mismatch (up to a cap, so a broken block does not
	// flood the log) and counts all of them.
	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_LIMIT)
			$display("[%0t] MISMATCH: %s", $time, msg);
		mismatches++;
	endtask

	// Steps the parser flags for one input transaction and tells whether it
	// gives a result token, and which one.
	task automatic parse_step(input logic op_i, input logic [7:0] b,
			output bit emits, output csv_token_t tok);
		bit handled;
		emits = 1'b0;
		handled = 1'b0;
		tok.kind = KIND_BYTE;
		tok.fbyte = 8'h00;
		if (op_i == OP_END) begin
			// A quote still waiting for its partner closes quoting first.
			if (quote_held)
				quoting = !quoting;
			if (quoting) begin
				emits = 1'b1;
				tok.kind = KIND_ERROR;
			end else if (record_started) begin
				emits = 1'b1;
				tok.kind = KIND_RECORD;
			end
			quoting = 1'b0;
			quote_held = 1'b0;
			after_cr = 1'b0;
			record_started = 1'b0;
		end else begin
			// An LF right after a record-ending CR is dropped silently.
			if (after_cr) begin
				after_cr = 1'b0;
				if (b == CH_LF)
					handled = 1'b1;
			end
			// A held quote is either doubled (literal quote) or closes quoting,
			// in which case the byte falls through as an unquoted byte.
			if (!handled && quote_held) begin
				quote_held = 1'b0;
				if (b == CH_QUOTE) begin
					record_started = 1'b1;
					emits = 1'b1;
					tok.fbyte = b;
					handled = 1'b1;
				end else begin
					quoting = 1'b0;
				end
			end
			if (!handled) begin
				if (quoting) begin
					if (b == CH_QUOTE) begin
						quote_held = 1'b1;
					end else begin
						record_started = 1'b1;
						emits = 1'b1;
						tok.fbyte = b;
					end
				end else if (b == CH_QUOTE) begin
					quoting = 1'b1;
				end else if (b == CH_COMMA) begin
					record_started = 1'b1;
					emits = 1'b1;
					tok.kind = KIND_FIELD;
				end else if (b == CH_CR || b == CH_LF) begin
					record_started = 1'b0;
					after_cr = (b == CH_CR);
					emits = 1'b1;
					tok.kind = KIND_RECORD;
				end else begin
					record_started = 1'b1;
					emits = 1'b1;
					tok.fbyte = b;
				end
			end
		end
	endtask

	// Idle lengths: mostly none or short, now and then a long one.
	function automatic int unsigned draw_idle();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic bit is_special(input logic [7:0] b);
		return b == CH_QUOTE || b == CH_COMMA || b == CH_CR || b == CH_LF;
	endfunction

	// Ordinary content byte for an unquoted field.
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		while (is_special(b))
			b = 8'($urandom_range(0, 255));
		return b;
	endfunction

	// Byte with the characters that matter to the parser strongly favored.
	function automatic logic [7:0] biased_byte();
		case ($urandom_range(0, 7))
			0: return CH_QUOTE;
			1: return CH_COMMA;
			2: return CH_CR;
			3: return CH_LF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic add_item(input logic op_i, input logic [7:0] b, input bit counts);
		csv_input_t it;
		it.op = op_i;
		it.data = b;
		pending_inputs = {pending_inputs, it};
		if (counts)
			generated++;
	endtask

	task automatic add_byte(input logic [7:0] b);
		add_item(OP_DATA, b, 1'b1);
	endtask

	task automatic add_end();
		add_item(OP_END, 8'($urandom_range(0, 255)), 1'b1);
	endtask

	// A quoted field: content may hold commas and line ends, and every quote
	// inside it is doubled.
	task automatic add_quoted_field();
		int n;
		logic [7:0] b;
		n = $urandom_range(0, 6);
		add_byte(CH_QUOTE);
		for (int i = 0; i < n; i++) begin
			b = ($urandom_range(0, 3) == 0) ? biased_byte() : 8'($urandom_range(0, 255));
			add_byte(b);
			if (b == CH_QUOTE)
				add_byte(CH_QUOTE);
		end
		add_byte(CH_QUOTE);
	endtask

	// A well-formed record of one to five fields, ended by a random line ending or the end of input.
	task automatic add_record();
		int nfields;
		int n;
		nfields = $urandom_range(1, 5);
		for (int f = 0; f < nfields; f++) begin
			if (f > 0)
				add_byte(CH_COMMA);
			if ($urandom_range(0, 2) == 0) begin
				add_quoted_field();
			end else begin
				n = $urandom_range(0, 6);
				for (int i = 0; i < n; i++)
					add_byte(plain_byte());
			end
		end
		case ($urandom_range(0, 9)) inside
			[0:4]: begin
				add_byte(CH_CR);
				add_item(OP_DATA, CH_LF, 1'b0);
			end
			[5:6]: add_byte(CH_LF);
			7: add_byte(CH_CR);
			8: add_end();
			default: begin
				add_byte(CH_LF);
				add_end();
			end
		endcase
	endtask

	// Random bytes and end markers with no structure at all.
	task automatic add_noise();
		int n;
		n = $urandom_range(1, 12);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				add_end();
			else
				add_byte(biased_byte());
		end
	endtask

	// Records cut short by the end of input while quoting is still open, or
	// with a quote still held.
	task automatic add_broken();
		int n;
		n = $urandom_range(0, 4);
		case ($urandom_range(0, 2))
			0: begin
				add_byte(CH_QUOTE);
				for (int i = 0; i < n; i++)
					add_byte(plain_byte());
			end
			1: begin
				add_byte(plain_byte());
				add_byte(CH_QUOTE);
				for (int i = 0; i < n; i++)
					add_byte(biased_byte());
			end
			default: begin
				for (int i = 0; i < n; i++)
					add_byte(plain_byte());
				add_byte(CH_QUOTE);
				add_byte(CH_QUOTE);
			end
		endcase
		add_end();
	endtask

	// Input driver. A transaction is accepted at an edge where in_valid is
	// high and in_stall low; that is also where the expected token is
	// predicted. The next values of the valid and payload are worked out
	// first and assigned once, so a valid that stays high is never lowered
	// and raised again in the same step.
	always @(posedge clk or negedge arst_n) begin : drive_inputs
		int unsigned send_gap;
		int unsigned send_burst;
		csv_input_t nxt;
		csv_token_t tok;
		bit emits;
		logic v_n;
		logic op_n;
		logic [7:0] b_n;
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= OP_DATA;
			data_byte <= 8'h00;
			send_gap = 0;
			send_burst = 0;
		end else begin
			v_n = in_valid;
			op_n = op;
			b_n = data_byte;
			if (in_valid && !in_stall) begin
				parse_step(op, data_byte, emits, tok);
				if (emits)
					expected_tokens = {expected_tokens, tok};
				v_n = 1'b0;
				// Now and then a long stretch goes out back to back.
				if (send_burst > 0) begin
					send_burst--;
					send_gap = 0;
				end else if ($urandom_range(0, 99) == 0) begin
					send_burst = $urandom_range(40, 120);
					send_gap = 0;
				end else begin
					send_gap = draw_idle();
				end
			end
			if (!v_n) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_inputs.size() != 0) begin
					nxt = pending_inputs.pop_front();
					v_n = 1'b1;
					op_n = nxt.op;
					b_n = nxt.data;
				end
			end
			in_valid <= v_n;
			op <= op_n;
			data_byte <= b_n;
		end
	end

	// Output monitor. Checks every accepted result against the oldest
	// expected token and drives random stall patterns on out_stall, with
	// occasional long stretches without any stall.
	always @(posedge clk or negedge arst_n) begin : watch_results
		int unsigned stall_left;
		int unsigned free_left;
		csv_token_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			free_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_tokens.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected: kind %0d byte %02h",
						kind, field_byte));
				end else begin
					want = expected_tokens.pop_front();
					if (kind !== want.kind)
						report_mismatch($sformatf("kind %0d, expected %0d",
							kind, want.kind));
					if (field_byte !== want.fbyte)
						report_mismatch($sformatf("field_byte %02h, expected %02h",
							field_byte, want.fbyte));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (free_left > 0) begin
				free_left--;
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 99) == 0) begin
				free_left = $urandom_range(40, 120);
				out_stall <= 1'b0;
			end else begin
				stall_left = draw_idle();
				if (stall_left > 0) begin
					stall_left--;
					out_stall <= 1'b1;
				end else begin
					out_stall <= 1'b0;
				end
			end
		end
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** csv_record_splitter: FAILED **");
			$finish;
		end
	end

	initial begin
		quoting = 1'b0;
		quote_held = 1'b0;
		after_cr = 1'b0;
		record_started = 1'b0;

		// Directed part. Plain field bytes, a comma, the byte extremes, and a
		// CR LF line end whose LF is swallowed.
		add_byte("a");
		add_byte(CH_COMMA);
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(CH_CR);
		add_byte(CH_LF);
		// Two CRs: the second is not an LF, so it ends an empty record.
		add_byte(CH_CR);
		add_byte(CH_CR);
		// Quoted field with an escaped quote and a CR kept as content; the
		// closing quote is resolved by the comma that follows.
		add_byte(CH_QUOTE);
		add_byte("x");
		add_byte(CH_QUOTE);
		add_byte(CH_QUOTE);
		add_byte(CH_CR);
		add_byte(CH_QUOTE);
		add_byte(CH_COMMA);
		// A quote in mid-field opens quoting, so the end of input reports an
		// unterminated quote.
		add_byte("b");
		add_byte(CH_QUOTE);
		add_item(OP_END, 8'hFF, 1'b1);
		// A record holding only an empty quoted section gives nothing at the
		// end of input, and neither does an end of input on empty state.
		add_byte(CH_QUOTE);
		add_byte(CH_QUOTE);
		add_item(OP_END, 8'h00, 1'b1);
		add_item(OP_END, 8'h00, 1'b1);
		// A started record is closed by the end of input.
		add_byte("c");
		add_end();
		// A bare LF on an empty record still ends a record; the end of input
		// after it has nothing to close.
		add_byte(CH_LF);
		add_end();

		// Random part: mostly well-formed records.
		generated = 0;
		while (generated < RANDOM_ITEMS) begin
			case ($urandom_range(0, 99)) inside
				[0:79]: add_record();
				[80:91]: add_noise();
				default: add_broken();
			endcase
		end

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Everything sent, every expected token received, then a drain wait
		// in which no further result may appear.
		while (pending_inputs.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		// A result still offered here was never predicted, even if the
		// receiver happens to be stalling it.
		if (out_valid)
			report_mismatch("result offered after the last expected one");

		if (mismatches == 0) begin
			$display("** csv_record_splitter: PASSED **");
		end else begin
			$display("** csv_record_splitter: FAILED **");
		end
		$finish;
	end

endmodule
